### rtl/ordered_array_list_engine_assert.svh
// Assertion macros shared by the checker module of the array list engine.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef ORDERED_ARRAY_LIST_ENGINE_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OALE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("array list check failed: %m");

// Next-cycle implication, disabled during reset.
`define OALE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("array list check failed: %m");

`endif

### rtl/oale_pkg.sv
// Shared types and codes for the ordered array list engine.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package oale_pkg;

    localparam int FUNC_W  = 3;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 8;

    localparam int DEF_LIST_DEPTH    = 128;
    localparam int DEF_ELEMENT_WIDTH = 32;

    localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd5;

    typedef logic [1:0] ptr_sel_t;
    localparam ptr_sel_t PS_ZERO = 2'd0;
    localparam ptr_sel_t PS_POS  = 2'd1;
    localparam ptr_sel_t PS_LAST = 2'd2;

    typedef logic [1:0] wa_sel_t;
    localparam wa_sel_t WA_LEN  = 2'd0;
    localparam wa_sel_t WA_POS  = 2'd1;
    localparam wa_sel_t WA_UP   = 2'd2;
    localparam wa_sel_t WA_DOWN = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] data_out;
        logic                      found;
        logic [POS_W-1:0]          found_position;
        logic [COUNT_W-1:0]        list_count;
        logic                      is_empty;
    } rsp_t;

    typedef struct packed {
        logic     capture;
        logic     ptr_load;
        ptr_sel_t ptr_sel;
        logic     ptr_inc;
        logic     ptr_dec;
        logic     mem_rd;
        logic     mem_wr;
        wa_sel_t  wa_sel;
        logic     wd_from_mem;
        logic     len_inc;
        logic     len_dec;
        logic     len_clr;
        logic     set_ok;
        logic     cap_data;
        logic     set_found;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              len_zero;
        logic              pos_lt_len;
        logic              pos_eq_len;
        logic              ptr_eq_len;
        logic              rdq_eq_pos;
        logic              match;
    } dp_status_t;

endpackage

### rtl/ordered_array_list_engine.sv
// Ordered array list engine: controller plus datapath over an element memory with one write and one read port.
// Append, clear, rejects and insert at the tail are settled in decode; read fetches the element once.
// Insert moves the elements from the tail down to the position up one slot; delete moves those above it down.
// Search walks from index 0 up to the first match or the end; an empty list is answered from decode.
// A new request is taken in the cycle after done; none is taken while busy.
// Reset (rst_n low, async) empties the list; memory contents are not cleared.
`timescale 1ns / 1ps

module ordered_array_list_engine #(
    parameter int LIST_DEPTH    = oale_pkg::DEF_LIST_DEPTH,
    parameter int ELEMENT_WIDTH = oale_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  oale_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output oale_pkg::rsp_t rsp
);
    import oale_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    oale_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    oale_datapath #(
        .LIST_DEPTH    (LIST_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule

### rtl/oale_datapath.sv
// Datapath of the array list engine: element memory, length, walk pointer, result.
// Depends on oale_pkg; driven by oale_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module oale_datapath #(
    parameter int LIST_DEPTH    = oale_pkg::DEF_LIST_DEPTH,
    parameter int ELEMENT_WIDTH = oale_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  oale_pkg::req_t      req,
    input  oale_pkg::dp_cmd_t   cmd,
    output oale_pkg::dp_status_t status,
    output oale_pkg::rsp_t      rsp
);
    import oale_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam int CW = LW + POS_W;

    logic [ELEMENT_WIDTH-1:0] mem [LIST_DEPTH];

    logic [FUNC_W-1:0]        func_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [ELEMENT_WIDTH-1:0] val_reg;
    logic [LW-1:0]            len_reg, len_next;
    logic [LW-1:0]            ptr_reg, ptr_next;
    logic [AW-1:0]            rdq_reg;
    logic [ELEMENT_WIDTH-1:0] rd_data_reg;
    logic                     ok_reg;
    logic [VALUE_W-1:0]       data_reg;
    logic                     found_reg;
    logic [POS_W-1:0]         fpos_reg;

    logic signed [63:0]       val_wide;
    logic signed [63:0]       rd_wide;
    logic [AW-1:0]            wr_addr;
    logic [ELEMENT_WIDTH-1:0] wr_data;

    assign val_wide = 64'(req.item_value);
    assign rd_wide  = 64'(signed'(rd_data_reg));

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.ptr_load)
        begin
            case (cmd.ptr_sel)
                PS_POS:  ptr_next = LW'(pos_reg);
                PS_LAST: ptr_next = LW'(len_reg - 1'b1);
                default: ptr_next = '0;
            endcase
        end
        else if (cmd.ptr_inc)
            ptr_next = LW'(ptr_reg + 1'b1);
        else if (cmd.ptr_dec)
            ptr_next = LW'(ptr_reg - 1'b1);
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.len_clr)
            len_next = '0;
        else if (cmd.len_inc)
            len_next = LW'(len_reg + 1'b1);
        else if (cmd.len_dec)
            len_next = LW'(len_reg - 1'b1);
    end

    always_comb
    begin
        case (cmd.wa_sel)
            WA_POS:  wr_addr = AW'(pos_reg);
            WA_UP:   wr_addr = AW'(rdq_reg + 1'b1);
            WA_DOWN: wr_addr = AW'(rdq_reg - 1'b1);
            default: wr_addr = AW'(len_reg);
        endcase
    end

    assign wr_data = cmd.wd_from_mem ? rd_data_reg : val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            ptr_reg <= ptr_next;
        end
    end

    // Walk memory: one write and one registered read per cycle, at separate addresses.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[wr_addr] <= wr_data;
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[ptr_reg[AW-1:0]];
            rdq_reg     <= ptr_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= req.func;
            pos_reg   <= req.position;
            val_reg   <= val_wide[ELEMENT_WIDTH-1:0];
            ok_reg    <= 1'b0;
            data_reg  <= '0;
            found_reg <= 1'b0;
            fpos_reg  <= '0;
        end
        else
        begin
            if (cmd.set_ok)
                ok_reg <= 1'b1;
            if (cmd.cap_data)
                data_reg <= rd_wide[VALUE_W-1:0];
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
                fpos_reg  <= POS_W'(rdq_reg);
            end
        end
    end

    assign status.func       = func_reg;
    assign status.full       = (len_reg == LW'(LIST_DEPTH));
    assign status.len_zero   = (len_reg == '0);
    assign status.pos_lt_len = (CW'(pos_reg) < CW'(len_reg));
    assign status.pos_eq_len = (CW'(pos_reg) == CW'(len_reg));
    assign status.ptr_eq_len = (ptr_reg == len_reg);
    assign status.rdq_eq_pos = (CW'(rdq_reg) == CW'(pos_reg));
    assign status.match      = (rd_data_reg == val_reg);

    assign rsp.ok             = ok_reg;
    assign rsp.data_out       = signed'(data_reg);
    assign rsp.found          = found_reg;
    assign rsp.found_position = fpos_reg;
    assign rsp.list_count     = COUNT_W'(len_reg);
    assign rsp.is_empty       = (len_reg == '0);

endmodule

### rtl/oale_ctrl.sv
// Controller of the array list engine: decodes a request and sequences the memory walk.
// Depends on oale_pkg; commands oale_datapath through dp_cmd_t.
`timescale 1ns / 1ps

module oale_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  oale_pkg::dp_status_t status,
    output oale_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import oale_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_UP_RD   = 4'd2;
    localparam logic [3:0] S_UP      = 4'd3;
    localparam logic [3:0] S_INS_PUT = 4'd4;
    localparam logic [3:0] S_DEL_RD  = 4'd5;
    localparam logic [3:0] S_DEL_GET = 4'd6;
    localparam logic [3:0] S_DOWN    = 4'd7;
    localparam logic [3:0] S_RD_RD   = 4'd8;
    localparam logic [3:0] S_RD_GET  = 4'd9;
    localparam logic [3:0] S_SRCH_RD = 4'd10;
    localparam logic [3:0] S_SRCH    = 4'd11;
    localparam logic [3:0] S_RESP    = 4'd12;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                case (status.func)
                    FUNC_APPEND:
                    begin
                        if (!status.full)
                        begin
                            cmd.mem_wr  = 1'b1;
                            cmd.wa_sel  = WA_LEN;
                            cmd.len_inc = 1'b1;
                            cmd.set_ok  = 1'b1;
                        end
                    end
                    FUNC_INSERT:
                    begin
                        if (!status.full && (status.pos_lt_len || status.pos_eq_len))
                        begin
                            cmd.set_ok = 1'b1;
                            if (status.pos_eq_len)
                            begin
                                cmd.mem_wr  = 1'b1;
                                cmd.wa_sel  = WA_POS;
                                cmd.len_inc = 1'b1;
                            end
                            else
                            begin
                                cmd.ptr_load = 1'b1;
                                cmd.ptr_sel  = PS_LAST;
                                state_next   = S_UP_RD;
                            end
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (status.pos_lt_len)
                        begin
                            cmd.set_ok   = 1'b1;
                            cmd.ptr_load = 1'b1;
                            cmd.ptr_sel  = PS_POS;
                            state_next   = S_DEL_RD;
                        end
                    end
                    FUNC_READ:
                    begin
                        if (status.pos_lt_len)
                        begin
                            cmd.set_ok   = 1'b1;
                            cmd.ptr_load = 1'b1;
                            cmd.ptr_sel  = PS_POS;
                            state_next   = S_RD_RD;
                        end
                    end
                    FUNC_SEARCH:
                    begin
                        cmd.set_ok = 1'b1;
                        if (!status.len_zero)
                        begin
                            cmd.ptr_load = 1'b1;
                            cmd.ptr_sel  = PS_ZERO;
                            state_next   = S_SRCH_RD;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.len_clr = 1'b1;
                        cmd.set_ok  = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_UP_RD:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.ptr_dec = 1'b1;
                state_next  = S_UP;
            end
            // Move the element just read one slot up; stop once the insert slot is vacated.
            S_UP:
            begin
                cmd.mem_wr      = 1'b1;
                cmd.wa_sel      = WA_UP;
                cmd.wd_from_mem = 1'b1;
                if (status.rdq_eq_pos)
                    state_next = S_INS_PUT;
                else
                begin
                    cmd.mem_rd  = 1'b1;
                    cmd.ptr_dec = 1'b1;
                end
            end
            S_INS_PUT:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wa_sel  = WA_POS;
                cmd.len_inc = 1'b1;
                state_next  = S_RESP;
            end
            S_DEL_RD:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next  = S_DEL_GET;
            end
            S_DEL_GET:
            begin
                cmd.cap_data = 1'b1;
                if (status.ptr_eq_len)
                begin
                    cmd.len_dec = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.mem_rd  = 1'b1;
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_DOWN;
                end
            end
            // Move the element just read one slot down; the last read closes the gap.
            S_DOWN:
            begin
                cmd.mem_wr      = 1'b1;
                cmd.wa_sel      = WA_DOWN;
                cmd.wd_from_mem = 1'b1;
                if (status.ptr_eq_len)
                begin
                    cmd.len_dec = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.mem_rd  = 1'b1;
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_RD_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_RD_GET;
            end
            S_RD_GET:
            begin
                cmd.cap_data = 1'b1;
                state_next   = S_RESP;
            end
            S_SRCH_RD:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next  = S_SRCH;
            end
            S_SRCH:
            begin
                if (status.match)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_RESP;
                end
                else if (status.ptr_eq_len)
                    state_next = S_RESP;
                else
                begin
                    cmd.mem_rd  = 1'b1;
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

endmodule

### rtl/oale_checker.sv
// Port-level checks for the ordered array list engine, bound to the top level.
// Depends on oale_pkg and ordered_array_list_engine_assert.svh.
`timescale 1ns / 1ps
`include "ordered_array_list_engine_assert.svh"

module oale_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input oale_pkg::rsp_t rsp
);
    import oale_pkg::*;

    `OALE_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
    `OALE_ASSERT_NEXT(a_one_result_per_request, done, !done)
    `OALE_ASSERT_NOW(a_empty_matches_count, done, rsp.is_empty == (rsp.list_count == '0))
    `OALE_ASSERT_NOW(a_reject_clean, done && !rsp.ok,
        (rsp.data_out == '0) && !rsp.found && (rsp.found_position == '0))
    `OALE_ASSERT_NOW(a_done_while_busy, done, busy)

endmodule

bind ordered_array_list_engine oale_checker u_oale_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

### dv/tb_ordered_array_list_engine.sv
// Testbench for ordered_array_list_engine: random and directed list requests, shadow list check.
// Depends on oale_pkg for the request and response types and the function codes.
`timescale 1ns / 1ps

module tb_ordered_array_list_engine;
    import oale_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int LIST_SLOTS   = DEF_LIST_DEPTH;
    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_PCT     = 36;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} walk_mode_t;

    // Shadow copy of the list; predicts one response per accepted request.
    class list_shadow;
        logic signed [VALUE_W-1:0] elems[$];
        rsp_t pending_rsp[$];
        int accepted;
        int rejected;
        int full_refusals;
        int search_hits;
        int peak_len;
        int compared;
        int mismatches;

        function int size_now();
            return elems.size();
        endfunction

        function int pending();
            return pending_rsp.size();
        endfunction

        function void apply_request(req_t r);
            rsp_t e;
            int k;
            int len;
            e = '0;
            len = elems.size();
            case (r.func)
                FUNC_APPEND:
                    if (len < LIST_SLOTS)
                    begin
                        elems.push_back(r.item_value);
                        e.ok = 1'b1;
                    end
                FUNC_INSERT:
                    if (len < LIST_SLOTS && int'(r.position) <= len)
                    begin
                        elems.insert(int'(r.position), r.item_value);
                        e.ok = 1'b1;
                    end
                FUNC_DELETE:
                    if (int'(r.position) < len)
                    begin
                        e.data_out = elems[r.position];
                        elems.delete(int'(r.position));
                        e.ok = 1'b1;
                    end
                FUNC_READ:
                    if (int'(r.position) < len)
                    begin
                        e.data_out = elems[r.position];
                        e.ok = 1'b1;
                    end
                FUNC_SEARCH:
                begin
                    e.ok = 1'b1;
                    for (k = 0; k < len && !e.found; k++)
                        if (elems[k] == r.item_value)
                        begin
                            e.found = 1'b1;
                            e.found_position = k[POS_W-1:0];
                        end
                    if (e.found)
                        search_hits++;
                end
                FUNC_CLEAR:
                begin
                    elems.delete();
                    e.ok = 1'b1;
                end
                default: ;
            endcase
            if (!e.ok)
                rejected++;
            if (!e.ok && len == LIST_SLOTS && (r.func == FUNC_APPEND || r.func == FUNC_INSERT))
                full_refusals++;
            e.list_count = COUNT_W'(elems.size());
            e.is_empty   = (elems.size() == 0);
            if (elems.size() > peak_len)
                peak_len = elems.size();
            accepted++;
            pending_rsp.push_back(e);
        endfunction

        function void report_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        endfunction

        function void compare_response(rsp_t act);
            rsp_t e;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response, expected none, actual %p", $time, act);
                return;
            end
            e = pending_rsp.pop_front();
            compared++;
            if (act.ok !== e.ok)
                report_field("ok", 32'(e.ok), 32'(act.ok));
            if (act.data_out !== e.data_out)
                report_field("data_out", e.data_out, act.data_out);
            if (act.found !== e.found)
                report_field("found", 32'(e.found), 32'(act.found));
            if (act.found_position !== e.found_position)
                report_field("found_position", 32'(e.found_position), 32'(act.found_position));
            if (act.list_count !== e.list_count)
                report_field("list_count", 32'(e.list_count), 32'(act.list_count));
            if (act.is_empty !== e.is_empty)
                report_field("is_empty", 32'(e.is_empty), 32'(act.is_empty));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    list_shadow shadow;

    ordered_array_list_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        if (rst_n && done)
            shadow.compare_response(rsp);

    function automatic req_t make_req(logic [FUNC_W-1:0] f, int pos, logic [31:0] v);
        req_t r;
        r.func       = f;
        r.position   = pos[POS_W-1:0];
        r.item_value = v;
        return r;
    endfunction

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Mostly well-formed requests for the current list; a few broken positions and junk codes.
    function automatic req_t random_request(walk_mode_t mode);
        req_t r;
        int len;
        int roll;
        int pick;
        len  = shadow.size_now();
        roll = $urandom_range(0, 99);
        r    = '0;
        if (roll >= 97)
        begin
            r.func       = FUNC_W'($urandom_range(0, 7));
            r.position   = POS_W'($urandom_range(0, 127));
            r.item_value = $urandom;
            return r;
        end
        case (mode)
            MODE_GROW:
                r.func = roll < 45 ? FUNC_APPEND : roll < 80 ? FUNC_INSERT :
                         roll < 88 ? FUNC_READ : roll < 95 ? FUNC_SEARCH : FUNC_DELETE;
            MODE_SHRINK:
                r.func = roll < 50 ? FUNC_DELETE : roll < 65 ? FUNC_READ :
                         roll < 80 ? FUNC_SEARCH : roll < 88 ? FUNC_INSERT :
                         roll < 96 ? FUNC_APPEND : FUNC_CLEAR;
            default:
                r.func = roll < 20 ? FUNC_APPEND : roll < 40 ? FUNC_INSERT :
                         roll < 55 ? FUNC_DELETE : roll < 70 ? FUNC_READ :
                         roll < 95 ? FUNC_SEARCH : FUNC_CLEAR;
        endcase

        pick = $urandom_range(0, 3);
        if (r.func == FUNC_INSERT)
            r.position = POS_W'(pick == 0 ? 0 : pick == 1 ? len : $urandom_range(0, len));
        else if (len > 0)
            r.position = POS_W'(pick == 0 ? 0 : pick == 1 ? len - 1 : $urandom_range(0, len - 1));
        else
            r.position = POS_W'($urandom_range(0, 127));
        if ($urandom_range(0, 99) < 8)
            r.position = POS_W'($urandom_range(0, 127));

        pick = $urandom_range(0, 9);
        if (pick <= 3)
            r.item_value = $urandom;
        else if (pick <= 5)
            r.item_value = $urandom_range(0, 15);
        else if (pick == 6 || len == 0 || r.func != FUNC_SEARCH)
            r.item_value = pick == 6 ? extreme_value() : $urandom;
        else
            r.item_value = shadow.elems[$urandom_range(0, len - 1)];
        return r;
    endfunction

    // Hold the request until the engine takes it, then note it in the shadow list.
    task automatic send_request(input req_t r);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shadow.apply_request(r);
    endtask

    // Drop start on a random number of cycles; scramble req while it is ignored.
    task automatic idle_gap();
        logic [63:0] junk;
        while ($urandom_range(0, 99) < IDLE_PCT)
        begin
            junk = {$urandom, $urandom};
            start <= 1'b0;
            req   <= junk[$bits(req_t)-1:0];
            @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        walk_mode_t mode;
        int left;
        int n;
        shadow = new();
        rst_n  = 1'b0;
        start  = 1'b0;
        req    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: every position is bad, search misses.
        send_request(make_req(FUNC_READ, 0, 0));
        send_request(make_req(FUNC_DELETE, 0, 0));
        send_request(make_req(FUNC_SEARCH, 0, 0));
        idle_gap();
        send_request(make_req(FUNC_INSERT, 1, 32'h5));
        send_request(make_req(FUNC_APPEND, 0, 32'h7FFF_FFFF));
        send_request(make_req(FUNC_APPEND, 127, 32'h8000_0000));
        send_request(make_req(FUNC_INSERT, 0, 32'hFFFF_FFFF));
        idle_gap();
        send_request(make_req(FUNC_INSERT, 3, 32'h0));
        send_request(make_req(FUNC_INSERT, 127, 32'h1));
        send_request(make_req(FUNC_READ, 0, 0));
        send_request(make_req(FUNC_READ, 3, 0));
        send_request(make_req(FUNC_READ, 4, 0));
        send_request(make_req(FUNC_READ, 127, 32'hFFFF_FFFF));
        idle_gap();
        send_request(make_req(FUNC_SEARCH, 0, 32'h8000_0000));
        send_request(make_req(FUNC_SEARCH, 0, 32'h1234_5678));
        send_request(make_req(FUNC_APPEND, 0, 32'h7FFF_FFFF));
        send_request(make_req(FUNC_SEARCH, 127, 32'h7FFF_FFFF));
        send_request(make_req(FUNC_DELETE, 127, 0));
        send_request(make_req(FUNC_DELETE, 0, 0));
        send_request(make_req(FUNC_DELETE, 3, 0));
        send_request(make_req(FUNC_UNUSED_LO, 1, 32'hAAAA_5555));
        send_request(make_req(FUNC_UNUSED_HI, 127, 32'h5555_AAAA));
        send_request(make_req(FUNC_DELETE, 1, 0));
        send_request(make_req(FUNC_CLEAR, 0, 0));
        send_request(make_req(FUNC_SEARCH, 0, 32'h0));
        send_request(make_req(FUNC_READ, 0, 0));
        wait_for_results();

        left = 0;
        mode = MODE_GROW;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (left == 0)
            begin
                case ($urandom_range(0, 2))
                    0: mode = MODE_GROW;
                    1: mode = MODE_SHRINK;
                    default: mode = MODE_MIXED;
                endcase
                left = mode == MODE_GROW ? $urandom_range(60, 200) : $urandom_range(20, 80);
            end
            send_request(random_request(mode));
            left--;
            if (n % 250 == 249)
                wait_for_results();
            else if (n < 400 || n >= 600)
                idle_gap();
        end

        wait_for_results();
        repeat (LIST_SLOTS + 20) @(posedge clk);

        $display("Run covered %0d requests: %0d rejected, %0d refused on a full list,",
                 shadow.accepted, shadow.rejected, shadow.full_refusals);
        $display("%0d search hits, peak length %0d, %0d responses compared, %0d mismatches.",
                 shadow.search_hits, shadow.peak_len, shadow.compared, shadow.mismatches);
        if (shadow.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout: engine stopped taking requests or returning responses");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/oale_pkg.sv
rtl/oale_datapath.sv
rtl/oale_ctrl.sv
rtl/ordered_array_list_engine.sv
rtl/oale_checker.sv
dv/tb_ordered_array_list_engine.sv
